// File: rtl/gper_pkg.sv
// ----------------------------------------------------------------------------
// GPIO expander port registers: shared definitions
// Command ranges, direction codes and the decoded command record.
// ----------------------------------------------------------------------------
package gper_pkg;

   localparam int PIN_COUNT = 32;
   localparam int PIN_W     = 5;
   localparam int RUN_MAX   = 8;
   localparam int LEN_W     = 4;

   localparam logic [7:0] CMD_CFG_LO   = 8'h09;
   localparam logic [7:0] CMD_CFG_HI   = 8'h0F;
   localparam logic [7:0] CMD_PIN_LO   = 8'h24;
   localparam logic [7:0] CMD_PIN_HI   = 8'h3F;
   localparam logic [7:0] CMD_RUN_LO   = 8'h40;
   localparam logic [7:0] CMD_SHORT_HI = 8'h44;
   localparam logic [7:0] CMD_RUN_HI   = 8'h5F;

   localparam logic [PIN_W-1:0] SHORT_RUN_BASE = 5'd4;
   localparam logic [LEN_W-1:0] SHORT_RUN_ADD  = 4'd4;
   localparam logic [LEN_W-1:0] LEN_ONE        = 4'd1;
   localparam logic [LEN_W-1:0] LEN_FULL       = 4'(RUN_MAX);

   localparam logic [1:0] DIR_FIELD_MASK = 2'h3;
   localparam logic [1:0] DIR_KEEP       = 2'b00;
   localparam logic [1:0] DIR_OUT        = 2'b01;

   localparam logic ACCESS_WRITE = 1'b0;
   localparam logic ACCESS_READ  = 1'b1;

   typedef struct packed {
      logic             is_cfg;
      logic             is_port;
      logic [2:0]       group;
      logic [PIN_W-1:0] base;
      logic [LEN_W-1:0] len;
   } decode_type;

endpackage

// File: rtl/gper_req_if.sv
// ----------------------------------------------------------------------------
// GPIO expander request channel
// Valid/ready channel carrying one register access per item.
// ----------------------------------------------------------------------------
interface gper_req_if;
   logic       valid;
   logic       ready;
   logic       req_type;
   logic [7:0] cmd_address;
   logic [7:0] write_data;

   modport source (output valid, req_type, cmd_address, write_data, input ready);
   modport sink   (input valid, req_type, cmd_address, write_data, output ready);
endinterface

// File: rtl/gper_rsp_if.sv
// ----------------------------------------------------------------------------
// GPIO expander response channel
// Valid/ready channel carrying one read byte per item.
// ----------------------------------------------------------------------------
interface gper_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] read_data;

   modport source (output valid, read_data, input ready);
   modport sink   (input valid, read_data, output ready);
endinterface

// File: rtl/gper_decode.sv
// ----------------------------------------------------------------------------
// GPIO expander command decoder
// Maps a command byte to direction group or pin run (base and length).
// ----------------------------------------------------------------------------
module gper_decode (
   input  logic [7:0]          cmd,
   output gper_pkg::decode_type dec
);
   import gper_pkg::*;

   always_comb begin
      dec = '0;
      if (cmd inside {[CMD_CFG_LO:CMD_CFG_HI]}) begin
         dec.is_cfg = 1'b1;
         dec.group  = cmd[2:0];
      end else if (cmd inside {[CMD_PIN_LO:CMD_PIN_HI]}) begin
         dec.is_port = 1'b1;
         dec.base    = cmd[PIN_W-1:0];
         dec.len     = LEN_ONE;
      end else if (cmd inside {[CMD_RUN_LO:CMD_SHORT_HI]}) begin
         dec.is_port = 1'b1;
         dec.base    = SHORT_RUN_BASE;
         dec.len     = {1'b0, cmd[2:0]} + SHORT_RUN_ADD;
      end else if (cmd inside {[CMD_RUN_LO:CMD_RUN_HI]}) begin
         dec.is_port = 1'b1;
         dec.base    = cmd[PIN_W-1:0];
         dec.len     = LEN_FULL;
      end
   end

endmodule

// File: rtl/gper_top_placeholder.sv
// ----------------------------------------------------------------------------
// GPIO expander pin run read
// Gathers up to eight stored pin levels, LSB first, from a base pin.
// ----------------------------------------------------------------------------
module gper_read_run (
   input  logic [31:0]          levels,
   input  gper_pkg::decode_type dec,
   output logic [7:0]           run_bits
);
   import gper_pkg::*;

   logic [PIN_W:0] pin_sum [RUN_MAX];

   always_comb begin
      run_bits = '0;
      for (int k = 0; k < RUN_MAX; k++) begin
         pin_sum[k] = {1'b0, dec.base} + (PIN_W+1)'(k);
         if ((LEN_W'(k) < dec.len) && !pin_sum[k][PIN_W]) begin
            run_bits[k] = levels[pin_sum[k][PIN_W-1:0]];
         end
      end
   end

endmodule

// File: rtl/gpio_expander_port_registers.sv
// ----------------------------------------------------------------------------
// GPIO expander port registers
// Register map of a 32-pin expander: direction setup and pin run access.
// ----------------------------------------------------------------------------
// Usage:
//   req_port carries one access per item: req_type (0 write, 1 read),
//   cmd_address and write_data. rsp_port returns one read_data byte for
//   every accepted item, in order; it is zero except for port reads.
//   An item is captured in an input register, decoded and applied to the
//   pin level and direction flops as it leaves that register, and its byte
//   lands in the output register, which drives rsp_port.valid. Throughput
//   is one item per cycle unless the output stalls, set by the single pass
//   through the decode and pin select logic between the two registers.
//   When the receiver stalls, the output register holds its item and the
//   input register can still take one more; req_port.ready drops only
//   when both are full.
//   Reset clears both registers' valid flags, all pin levels to 0 and all
//   pins to outputs.
// ----------------------------------------------------------------------------
module gpio_expander_port_registers (
   input  logic       clock,
   input  logic       reset,
   gper_req_if.sink   req_port,
   gper_rsp_if.source rsp_port
);
   import gper_pkg::*;

   logic       in_valid_ff, in_valid_in;
   logic       in_type_ff;
   logic [7:0] in_cmd_ff;
   logic [7:0] in_data_ff;
   logic       out_valid_ff, out_valid_in;
   logic [7:0] out_data_ff, out_data_in;
   logic [31:0] levels_ff, levels_in;
   logic [31:0] dir_ff, dir_in;

   decode_type     dec;
   logic [7:0]     run_bits;
   logic           advance;
   logic [PIN_W:0] offset [PIN_COUNT];
   logic [1:0]     code [4];

   gper_decode u_decode (
      .cmd (in_cmd_ff),
      .dec (dec)
   );

   gper_read_run u_read_run (
      .levels   (levels_ff),
      .dec      (dec),
      .run_bits (run_bits)
   );

   assign advance        = in_valid_ff && (!out_valid_ff || rsp_port.ready);
   assign req_port.ready = !in_valid_ff || advance;
   assign rsp_port.valid     = out_valid_ff;
   assign rsp_port.read_data = out_data_ff;

   assign in_valid_in  = req_port.ready ? req_port.valid : in_valid_ff;
   assign out_valid_in = advance ? 1'b1 : (rsp_port.ready ? 1'b0 : out_valid_ff);
   assign out_data_in  = (dec.is_port && in_type_ff == ACCESS_READ) ? run_bits : 8'h00;

   always_comb begin
      levels_in = levels_ff;
      for (int p = 0; p < PIN_COUNT; p++) begin
         offset[p] = (PIN_W+1)'(p) - {1'b0, dec.base};
         if (dec.is_port && in_type_ff == ACCESS_WRITE && !dir_ff[p]
             && (PIN_W'(p) >= dec.base) && (offset[p] < {2'b00, dec.len})) begin
            levels_in[p] = in_data_ff[offset[p][2:0]];
         end
      end
   end

   always_comb begin
      dir_in = dir_ff;
      for (int i = 0; i < 4; i++) begin
         code[i] = in_data_ff[2*i +: 2] & DIR_FIELD_MASK;
         if (dec.is_cfg) begin
            if (code[i] == DIR_OUT) begin
               dir_in[{dec.group, 2'(i)}] = 1'b0;
            end else if (code[i] != DIR_KEEP) begin
               dir_in[{dec.group, 2'(i)}] = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         levels_ff    <= '0;
         dir_ff       <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            levels_ff <= levels_in;
            dir_ff    <= dir_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_port.valid && req_port.ready) begin
         in_type_ff <= req_port.req_type;
         in_cmd_ff  <= req_port.cmd_address;
         in_data_ff <= req_port.write_data;
      end
      if (advance) begin
         out_data_ff <= out_data_in;
      end
   end

   // input pins never change their stored level
   assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> (((levels_ff ^ $past(levels_ff)) & $past(dir_ff)) == '0))
      else $error("input pin level changed");

   // state moves only with an item leaving the input register
   assert property (@(posedge clock) disable iff (reset)
      !advance |=> ($stable(levels_ff) && $stable(dir_ff)))
      else $error("pin state changed without an item");

   // back-pressure only when both registers are full and the output stalls
   assert property (@(posedge clock) disable iff (reset)
      !req_port.ready |-> (in_valid_ff && out_valid_ff && !rsp_port.ready))
      else $error("request stalled with room available");

   // a stalled input item is kept
   assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(in_cmd_ff)))
      else $error("pending item lost");

endmodule

// File: tb/sv/gpio_expander_port_registers_tb.sv
// ----------------------------------------------------------------------------
// GPIO expander port registers: testbench
// Drives register accesses on req_port and checks each read byte on rsp_port
// against a local model of the pin levels and directions. A short table of
// directed accesses comes first, then random accesses under four handshake
// phases, with a full drain of outstanding results between phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module gpio_expander_port_registers_tb;
   import gper_pkg::*;

   localparam int CYCLE_LIMIT      = 200000;
   localparam int ITEMS_PER_PHASE  = 406;
   localparam int PHASE_COUNT      = 4;
   localparam int DIRECTED_COUNT   = 25;
   localparam int PINS_PER_GROUP   = 4;
   localparam int TAIL_CYCLES      = 4;
   localparam int PRINT_CAP        = 30;

   localparam logic [7:0] CMD_ZERO = 8'h00;
   localparam logic [7:0] CMD_TOP  = 8'hFF;

   localparam logic TYPED   = 1'b1;
   localparam logic PREDICT = 1'b0;

   typedef struct packed {
      logic       is_read;
      logic [7:0] cmd;
      logic [7:0] data;
      logic       typed;
      logic [7:0] known;
   } access_row_type;

   logic clock;
   logic reset;

   gper_req_if req_bus ();
   gper_rsp_if rsp_bus ();

   gpio_expander_port_registers i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_bus),
      .rsp_port (rsp_bus)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   logic [PIN_COUNT-1:0] pin_levels   = '0;
   logic [PIN_COUNT-1:0] pin_is_input = '0;

   logic [7:0] pending_bytes [$];

   int cycle_count      = 0;
   int mismatch_count   = 0;
   int checked_count    = 0;
   int read_count       = 0;
   int write_count      = 0;
   int direction_count  = 0;
   int port_count       = 0;
   int unused_count     = 0;
   int sender_idle_pct  = 0;
   int receiver_stall_pct = 0;

   int sender_idle_by_phase   [PHASE_COUNT] = '{0, 49, 0, 19};
   int receiver_stall_by_phase [PHASE_COUNT] = '{0, 0, 49, 19};

   access_row_type directed_rows [DIRECTED_COUNT] = '{
      '{ACCESS_READ,  CMD_PIN_LO,           8'h00, TYPED,   8'h00},
      '{ACCESS_READ,  CMD_RUN_HI,           8'hFF, TYPED,   8'h00},
      '{ACCESS_WRITE, CMD_RUN_LO,           8'hFF, TYPED,   8'h00},
      '{ACCESS_WRITE, CMD_RUN_LO + 8'd5,    8'hFF, TYPED,   8'h00},
      '{ACCESS_WRITE, CMD_RUN_LO + 8'd24,   8'hA5, TYPED,   8'h00},
      '{ACCESS_READ,  CMD_RUN_LO,           8'h00, PREDICT, 8'h00},
      '{ACCESS_READ,  CMD_SHORT_HI,         8'h00, PREDICT, 8'h00},
      '{ACCESS_READ,  CMD_RUN_LO + 8'd25,   8'h00, PREDICT, 8'h00},
      '{ACCESS_READ,  CMD_RUN_HI,           8'h00, PREDICT, 8'h00},
      '{ACCESS_READ,  CMD_PIN_HI,           8'h00, PREDICT, 8'h00},
      '{ACCESS_WRITE, CMD_CFG_LO,           8'hAA, TYPED,   8'h00},
      '{ACCESS_READ,  CMD_CFG_HI,           8'hFF, TYPED,   8'h00},
      '{ACCESS_WRITE, CMD_RUN_LO,           8'h00, TYPED,   8'h00},
      '{ACCESS_READ,  CMD_RUN_LO,           8'h00, PREDICT, 8'h00},
      '{ACCESS_WRITE, CMD_CFG_LO,           8'h00, TYPED,   8'h00},
      '{ACCESS_WRITE, CMD_CFG_LO,           8'h55, TYPED,   8'h00},
      '{ACCESS_WRITE, CMD_PIN_LO,           8'h00, TYPED,   8'h00},
      '{ACCESS_READ,  CMD_PIN_LO,           8'h00, PREDICT, 8'h00},
      '{ACCESS_WRITE, CMD_RUN_HI,           8'h00, TYPED,   8'h00},
      '{ACCESS_READ,  CMD_ZERO,             8'hFF, TYPED,   8'h00},
      '{ACCESS_READ,  CMD_PIN_LO - 8'd1,    8'hFF, TYPED,   8'h00},
      '{ACCESS_READ,  CMD_RUN_HI + 8'd1,    8'hFF, TYPED,   8'h00},
      '{ACCESS_WRITE, CMD_TOP,              8'hFF, TYPED,   8'h00},
      '{ACCESS_WRITE, CMD_CFG_HI,           8'h55, TYPED,   8'h00},
      '{ACCESS_READ,  CMD_RUN_HI,           8'hFF, PREDICT, 8'h00}
   };

   function automatic logic [7:0] predict_access(logic is_read, logic [7:0] cmd,
                                                 logic [7:0] data);
      int         base_pin;
      int         run_len;
      int         k;
      logic [1:0] code;
      logic [7:0] byte_out;
      byte_out = '0;
      base_pin = 0;
      run_len  = 0;
      if (cmd >= CMD_CFG_LO && cmd <= CMD_CFG_HI) begin
         base_pin = (int'(cmd) - int'(CMD_CFG_LO) + 1) * PINS_PER_GROUP;
         for (k = 0; k < PINS_PER_GROUP; k++) begin
            code = data[2*k +: 2];
            if (base_pin + k < PIN_COUNT) begin
               if (code == DIR_OUT) begin
                  pin_is_input[base_pin + k] = 1'b0;
               end else if (code != DIR_KEEP) begin
                  pin_is_input[base_pin + k] = 1'b1;
               end
            end
         end
      end else if (cmd >= CMD_PIN_LO && cmd <= CMD_PIN_HI) begin
         base_pin = int'(cmd) - int'(CMD_PIN_LO) + PINS_PER_GROUP;
         run_len  = 1;
      end else if (cmd >= CMD_RUN_LO && cmd <= CMD_SHORT_HI) begin
         base_pin = int'(SHORT_RUN_BASE);
         run_len  = int'(cmd) - int'(CMD_RUN_LO) + int'(SHORT_RUN_ADD);
      end else if (cmd > CMD_SHORT_HI && cmd <= CMD_RUN_HI) begin
         base_pin = int'(cmd) - int'(CMD_RUN_LO);
         run_len  = PIN_COUNT - base_pin;
         if (run_len > RUN_MAX) begin
            run_len = RUN_MAX;
         end
      end
      for (k = 0; k < run_len && base_pin + k < PIN_COUNT; k++) begin
         if (is_read == ACCESS_READ) begin
            byte_out[k] = pin_levels[base_pin + k];
         end else if (!pin_is_input[base_pin + k]) begin
            pin_levels[base_pin + k] = data[k];
         end
      end
      return byte_out;
   endfunction

   function automatic logic [7:0] pick_command();
      int sel;
      logic [7:0] cmd;
      sel = $urandom_range(99);
      if (sel < 15) begin
         cmd = CMD_CFG_LO + 8'($urandom_range(6));
      end else if (sel < 35) begin
         cmd = CMD_PIN_LO + 8'($urandom_range(27));
      end else if (sel < 75) begin
         cmd = CMD_RUN_LO + 8'($urandom_range(31));
      end else if (sel < 85) begin
         case ($urandom_range(2))
            0:       cmd = 8'($urandom_range(int'(CMD_CFG_LO) - 1));
            1:       cmd = CMD_CFG_HI + 8'd1 + 8'($urandom_range(
                              int'(CMD_PIN_LO) - int'(CMD_CFG_HI) - 2));
            default: cmd = CMD_RUN_HI + 8'd1 + 8'($urandom_range(
                              int'(CMD_TOP) - int'(CMD_RUN_HI) - 1));
         endcase
      end else begin
         cmd = 8'($urandom_range(255));
      end
      return cmd;
   endfunction

   task automatic report_mismatch(input string what, input logic [7:0] got,
                                  input logic [7:0] want);
      if (mismatch_count < PRINT_CAP) begin
         $display("ERROR at cycle %0d, %s: read_data %02h, expected %02h",
                  cycle_count, what, got, want);
      end
      mismatch_count++;
   endtask

   task automatic send_access(input access_row_type row);
      logic [7:0] want;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.req_type    <= row.is_read;
      req_bus.cmd_address <= row.cmd;
      req_bus.write_data  <= row.data;
      @(posedge clock);
      while (req_bus.ready !== 1'b1) begin
         @(posedge clock);
      end
      want = predict_access(row.is_read, row.cmd, row.data);
      if (row.typed == TYPED) begin
         want = row.known;
      end
      pending_bytes.push_back(want);
      if (row.is_read == ACCESS_READ) begin
         read_count++;
      end else begin
         write_count++;
      end
      if (row.cmd >= CMD_CFG_LO && row.cmd <= CMD_CFG_HI) begin
         direction_count++;
      end else if (row.cmd >= CMD_PIN_LO && row.cmd <= CMD_RUN_HI) begin
         port_count++;
      end else begin
         unused_count++;
      end
   endtask

   task automatic drain_results();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending_bytes.size() != 0) begin
         @(posedge clock);
      end
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   always @(posedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   always @(posedge clock) begin
      logic [7:0] want;
      if (reset == 1'b0 && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         checked_count++;
         if (pending_bytes.size() == 0) begin
            report_mismatch("item with none pending", rsp_bus.read_data, 8'h00);
         end else begin
            want = pending_bytes.pop_front();
            if (rsp_bus.read_data !== want) begin
               report_mismatch("read_data", rsp_bus.read_data, want);
            end
         end
      end
   end

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
      end
      $display("Timeout after %0d cycles with %0d items pending",
               cycle_count, pending_bytes.size());
      $display("FAILED: results differ");
      $finish;
   end

   initial begin : stimulus
      access_row_type row;
      int             phase;
      int             n;
      reset               = 1'b1;
      req_bus.valid       = 1'b0;
      req_bus.req_type    = ACCESS_WRITE;
      req_bus.cmd_address = CMD_ZERO;
      req_bus.write_data  = 8'h00;
      rsp_bus.ready       = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (n = 0; n < DIRECTED_COUNT; n++) begin
         send_access(directed_rows[n]);
      end
      drain_results();

      for (phase = 0; phase < PHASE_COUNT; phase++) begin
         sender_idle_pct    = sender_idle_by_phase[phase];
         receiver_stall_pct = receiver_stall_by_phase[phase];
         for (n = 0; n < ITEMS_PER_PHASE; n++) begin
            row.is_read = 1'($urandom_range(1));
            row.cmd     = pick_command();
            row.data    = 8'($urandom_range(255));
            row.typed   = PREDICT;
            row.known   = 8'h00;
            send_access(row);
         end
         // hold off until every outstanding item has come back
         drain_results();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      $display("Covered %0d accesses (%0d reads, %0d writes): %0d direction, %0d port,",
               read_count + write_count, read_count, write_count, direction_count,
               port_count);
      $display("%0d unused commands; %0d results checked over %0d handshake phases",
               unused_count, checked_count, PHASE_COUNT);
      if (mismatch_count == 0 && pending_bytes.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

// File: gpio_expander_port_registers.f
rtl/gper_pkg.sv
rtl/gper_req_if.sv
rtl/gper_rsp_if.sv
rtl/gper_decode.sv
rtl/gper_top_placeholder.sv
rtl/gpio_expander_port_registers.sv
tb/sv/gpio_expander_port_registers_tb.sv
